// ===== rtl/srscwc_pkg.sv =====
// shared types and constants for the steering rate sign change window counter
package srscwc_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_RATE_MARGIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 1'd1;

  localparam logic [23:0] RATE_MARGIN_RST = 24'd6554;
  localparam logic [31:0] WINDOW_LEN_RST  = 32'd5000000;

  // angle delta is scaled to match microsecond timestamps
  localparam logic [23:0] RATE_SCALE = 24'd1000000;

  localparam logic [1:0] CLS_ZERO = 2'd0;
  localparam logic [1:0] CLS_POS  = 2'd1;
  localparam logic [1:0] CLS_NEG  = 2'd2;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_RUN    = 2'd2;

  typedef struct packed {
    logic signed [19:0] tire_angle;
    logic [47:0]        time_us;
  } in_item_t;

  typedef struct packed {
    logic        stats_valid;
    logic [1:0]  rate_class;
    logic        change_event;
    logic [6:0]  count_in_window;
    logic [31:0] total_changes;
    logic [6:0]  min_window_count;
    logic [6:0]  max_window_count;
    logic [47:0] window_count_sum;
    logic [31:0] sample_count;
    logic        window_overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_LHS,
    S_MUL_LO,
    S_MUL_HI,
    S_CLASSIFY,
    S_PUSH,
    S_PRUNE_RD,
    S_PRUNE_CMP,
    S_STATS,
    S_DONE
  } state_t;

endpackage

// ===== rtl/srscwc_ram.sv =====
// generic single write port ram with registered read
module srscwc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/srscwc_mul.sv =====
// shared 24x24 unsigned multiplier with registered product
module srscwc_mul (
  input  logic        clk,
  input  logic [23:0] mul_a,
  input  logic [23:0] mul_b,
  output logic [47:0] mul_p
);

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

endmodule

// ===== rtl/steer_rate_sign_change_window_counter_top.sv =====
// top level: sequencer, classification datapath, change ring and window statistics
//
// Counts steering direction changes over a sliding time window. Each item is a
// timestamped steering angle; one result item comes back for every input item.
// The first two items only prime the stored angle and time. A running item steps
// through the multiply, classify and push states, then pops stale ring entries
// (one ring read and one compare per pop) until the ring is empty or its oldest
// entry is fresh; its result may wait for a stalled output register.
// The rate test runs three passes through one shared
// 24x24 multiplier (angle delta times 1e6, then margin times the low and high
// 20 bits of the time delta), and pruning is bound by the ring's single read
// port. The block takes a new item while the last result still waits in the
// output register. The ring needs no clearing after reset.
module steer_rate_sign_change_window_counter_top #(
  parameter int RING_DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  srscwc_pkg::in_item_t                   in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output srscwc_pkg::out_item_t                  out_data,
  input  logic                                   cfg_we,
  input  logic [srscwc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [srscwc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int SW = AW + 1;
  localparam logic [AW-1:0] HEAD_LAST  = AW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] FILL_FULL  = CW'(RING_DEPTH);
  localparam logic [CW-1:0] FILL_ALMOST = CW'(RING_DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_SW   = SW'(RING_DEPTH);

  srscwc_pkg::state_t state_r, state_nxt;

  logic [23:0] rate_margin_r;
  logic [31:0] window_len_r;

  logic [1:0]  phase_r;
  logic [19:0] last_angle_r;
  logic [47:0] last_time_r;
  logic [1:0]  last_class_r;
  logic [AW-1:0] head_r;
  logic [CW-1:0] fill_r;
  logic [31:0] total_r;
  logic [CW-1:0] min_r;
  logic [CW-1:0] max_r;
  logic [47:0] sum_r;
  logic [31:0] samples_r;

  logic [19:0] cur_angle_r;
  logic [47:0] cur_time_r;
  logic [20:0] diff_r;
  logic [47:0] dt_r;
  logic        dt_pos_r;
  logic [39:0] lhs_r;
  logic [43:0] rlo_r;
  logic        res_valid_r;
  logic [1:0]  cls_r;
  logic        ev_r;
  logic        ovf_r;

  srscwc_pkg::out_item_t out_data_r;
  logic                  out_valid_r;

  logic        in_accept;
  logic        out_free;
  logic [23:0] mul_a;
  logic [23:0] mul_b;
  logic [47:0] mul_p;
  logic        ram_we;
  logic        ram_re;
  logic [AW-1:0] ram_waddr;
  logic [47:0] ram_rdata;

  logic [20:0] mag_w;
  logic [63:0] rhs_w;
  logic        zero_w;
  logic [1:0]  cls_nxt;
  logic        push_w;
  logic        full_w;
  logic [AW-1:0] head_inc_w;
  logic [AW-1:0] head_push_nxt;
  logic [CW-1:0] fill_push_nxt;
  logic [SW-1:0] wpos_w;
  logic [47:0] age_w;
  logic        stale_w;
  logic [48:0] sum_add_w;
  logic [CW+6:0] fill_ext_w;
  logic [CW+6:0] min_ext_w;
  logic [CW+6:0] max_ext_w;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  srscwc_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  srscwc_ram #(
    .WIDTH (48),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cur_time_r),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_margin_r <= srscwc_pkg::RATE_MARGIN_RST;
      window_len_r  <= srscwc_pkg::WINDOW_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        srscwc_pkg::REG_RATE_MARGIN: rate_margin_r <= cfg_wdata[23:0];
        srscwc_pkg::REG_WINDOW_LEN:  window_len_r  <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // classification
  assign mag_w  = diff_r[20] ? (~diff_r + 21'd1) : diff_r;
  assign rhs_w  = {20'd0, rlo_r} + {mul_p[43:0], 20'd0};
  assign zero_w = !dt_pos_r
               || ((rate_margin_r != 24'd0) && (dt_r[47:40] != 8'd0))
               || ({24'd0, lhs_r} < rhs_w);
  assign cls_nxt = zero_w ? srscwc_pkg::CLS_ZERO :
                   (!diff_r[20] && (diff_r != 21'd0)) ? srscwc_pkg::CLS_POS :
                   srscwc_pkg::CLS_NEG;

  // ring push, dropping the oldest entry when full
  assign push_w        = (cls_r != last_class_r) && (cls_r != srscwc_pkg::CLS_ZERO);
  assign full_w        = (fill_r >= FILL_FULL);
  assign head_inc_w    = (head_r == HEAD_LAST) ? '0 : head_r + AW'(1);
  assign head_push_nxt = full_w ? head_inc_w : head_r;
  assign fill_push_nxt = full_w ? FILL_ALMOST : fill_r;
  always_comb begin
    wpos_w = {1'b0, head_push_nxt} + SW'(fill_push_nxt);
    if (wpos_w >= DEPTH_SW) begin
      wpos_w = wpos_w - DEPTH_SW;
    end
  end
  assign ram_waddr = wpos_w[AW-1:0];

  // entries from the future are never stale
  assign age_w   = cur_time_r - ram_rdata;
  assign stale_w = (cur_time_r >= ram_rdata) && (age_w > {16'd0, window_len_r});

  assign sum_add_w = {1'b0, sum_r} + 49'(fill_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srscwc_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = (phase_r == srscwc_pkg::PH_RUN) ? srscwc_pkg::S_MUL_LHS :
                                                         srscwc_pkg::S_DONE;
        end
      end
      srscwc_pkg::S_MUL_LHS:  state_nxt = srscwc_pkg::S_MUL_LO;
      srscwc_pkg::S_MUL_LO:   state_nxt = srscwc_pkg::S_MUL_HI;
      srscwc_pkg::S_MUL_HI:   state_nxt = srscwc_pkg::S_CLASSIFY;
      srscwc_pkg::S_CLASSIFY: state_nxt = srscwc_pkg::S_PUSH;
      srscwc_pkg::S_PUSH:     state_nxt = srscwc_pkg::S_PRUNE_RD;
      srscwc_pkg::S_PRUNE_RD: begin
        state_nxt = (fill_r == '0) ? srscwc_pkg::S_STATS : srscwc_pkg::S_PRUNE_CMP;
      end
      srscwc_pkg::S_PRUNE_CMP: begin
        state_nxt = stale_w ? srscwc_pkg::S_PRUNE_RD : srscwc_pkg::S_STATS;
      end
      srscwc_pkg::S_STATS:    state_nxt = srscwc_pkg::S_DONE;
      srscwc_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = srscwc_pkg::S_IDLE;
        end
      end
      default: state_nxt = srscwc_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    mul_a    = rate_margin_r;
    mul_b    = {4'd0, dt_r[19:0]};
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    case (state_r)
      srscwc_pkg::S_IDLE: in_stall = 1'b0;
      srscwc_pkg::S_MUL_LHS: begin
        mul_a = {4'd0, mag_w[19:0]};
        mul_b = srscwc_pkg::RATE_SCALE;
      end
      srscwc_pkg::S_MUL_LO: mul_b = {4'd0, dt_r[19:0]};
      srscwc_pkg::S_MUL_HI: mul_b = {4'd0, dt_r[39:20]};
      srscwc_pkg::S_PUSH:   ram_we = push_w;
      srscwc_pkg::S_PRUNE_RD: ram_re = (fill_r != '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srscwc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // stored state and statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= srscwc_pkg::PH_FIRST;
      last_angle_r <= '0;
      last_time_r  <= '0;
      last_class_r <= srscwc_pkg::CLS_ZERO;
      head_r       <= '0;
      fill_r       <= '0;
      total_r      <= '0;
      min_r        <= FILL_FULL;
      max_r        <= '0;
      sum_r        <= '0;
      samples_r    <= '0;
    end else begin
      case (state_r)
        srscwc_pkg::S_IDLE: begin
          if (in_accept) begin
            if (phase_r == srscwc_pkg::PH_FIRST) begin
              last_angle_r <= in_data.tire_angle;
              last_time_r  <= in_data.time_us;
              phase_r      <= srscwc_pkg::PH_SECOND;
            end else if (phase_r == srscwc_pkg::PH_SECOND) begin
              last_time_r  <= in_data.time_us;
              phase_r      <= srscwc_pkg::PH_RUN;
            end
          end
        end
        srscwc_pkg::S_PUSH: begin
          if (push_w) begin
            head_r <= head_push_nxt;
            fill_r <= fill_push_nxt + CW'(1);
            if (total_r != '1) begin
              total_r <= total_r + 32'd1;
            end
          end
        end
        srscwc_pkg::S_PRUNE_CMP: begin
          if (stale_w) begin
            head_r <= head_inc_w;
            fill_r <= fill_r - CW'(1);
          end
        end
        srscwc_pkg::S_STATS: begin
          if (fill_r < min_r) begin
            min_r <= fill_r;
          end
          if (fill_r > max_r) begin
            max_r <= fill_r;
          end
          sum_r <= sum_add_w[48] ? '1 : sum_add_w[47:0];
          if (samples_r != '1) begin
            samples_r <= samples_r + 32'd1;
          end
          last_angle_r <= cur_angle_r;
          last_time_r  <= cur_time_r;
          last_class_r <= cls_r;
        end
        default: ;
      endcase
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    case (state_r)
      srscwc_pkg::S_IDLE: begin
        if (in_accept) begin
          cur_angle_r <= in_data.tire_angle;
          cur_time_r  <= in_data.time_us;
          diff_r      <= {in_data.tire_angle[19], in_data.tire_angle}
                       - {last_angle_r[19], last_angle_r};
          dt_r        <= in_data.time_us - last_time_r;
          dt_pos_r    <= (in_data.time_us > last_time_r);
          res_valid_r <= 1'b0;
          cls_r       <= srscwc_pkg::CLS_ZERO;
          ev_r        <= 1'b0;
          ovf_r       <= 1'b0;
        end
      end
      srscwc_pkg::S_MUL_LO:   lhs_r <= mul_p[39:0];
      srscwc_pkg::S_MUL_HI:   rlo_r <= mul_p[43:0];
      srscwc_pkg::S_CLASSIFY: cls_r <= cls_nxt;
      srscwc_pkg::S_PUSH: begin
        ev_r  <= push_w;
        ovf_r <= push_w && full_w;
      end
      srscwc_pkg::S_STATS: res_valid_r <= 1'b1;
      default: ;
    endcase
  end

  // output register, loaded once the item's work is done
  assign fill_ext_w = {7'd0, fill_r};
  assign min_ext_w  = {7'd0, min_r};
  assign max_ext_w  = {7'd0, max_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == srscwc_pkg::S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == srscwc_pkg::S_DONE) && out_free) begin
      out_data_r.stats_valid      <= res_valid_r;
      out_data_r.rate_class       <= cls_r;
      out_data_r.change_event     <= ev_r;
      out_data_r.count_in_window  <= fill_ext_w[6:0];
      out_data_r.total_changes    <= total_r;
      out_data_r.min_window_count <= min_ext_w[6:0];
      out_data_r.max_window_count <= max_ext_w[6:0];
      out_data_r.window_count_sum <= sum_r;
      out_data_r.sample_count     <= samples_r;
      out_data_r.window_overflow  <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("ring fill above depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= HEAD_LAST)
    else $error("ring head out of range");

  a_stats_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srscwc_pkg::S_DONE && res_valid_r) |-> (min_r <= fill_r && fill_r <= max_r))
    else $error("window count outside min and max");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("item accepted while previous item in progress");

endmodule
